/* rtl/ttba_pkg.sv */
// ----------------------------------------------------------------------------
// ttba_pkg
// Types, widths and helpers shared by the tiled texture address pipeline.
// ----------------------------------------------------------------------------
package ttba_pkg;

	// configuration register file
	localparam int CFG_W   = 32;
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH      = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TILED_LEN  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_LINEAR_LEN = 2'd3;

	localparam int WIDTH_W = 14;
	localparam int BB_W    = 5;
	localparam int LG_W    = 3;
	localparam logic [WIDTH_W-1:0] MAX_WIDTH_BLOCKS = 14'd8192;

	// field widths
	localparam int OFS_W  = 24;
	localparam int X_W    = 13;
	localparam int Y_W    = 20;
	localparam int TIDX_W = 28;
	localparam int TEND_W = TIDX_W + 1;
	localparam int LIDX_W = 38;
	localparam int MUL_W  = Y_W + WIDTH_W;

	// tiled offset after the macro-tile squeeze
	localparam int OT_W  = 25;
	// macro-tile index = quotient width, one divider cell per bit
	localparam int QUO_W = OT_W - 7;
	// macro-tile groups per row: 1 .. MAX_WIDTH_BLOCKS/32
	localparam int GRP_W = $clog2(MAX_WIDTH_BLOCKS / 32 + 1);
	localparam int REM_W = GRP_W - 1;

	typedef struct packed {
		logic [OFS_W-1:0] off;
		logic [1:0]       tx;
		logic [1:0]       ty;
		logic [2:0]       ux;
		logic [2:0]       uy;
		logic             b4;
	} side_t;

	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic [QUO_W-1:0] data;
		side_t            side;
	} stage_t;

	function automatic logic [LG_W-1:0] size_log2(input logic [BB_W-1:0] bb);
		logic [LG_W-1:0] lg;
		if (bb >= 5'd16) lg = 3'd4;
		else if (bb >= 5'd8) lg = 3'd3;
		else if (bb >= 5'd4) lg = 3'd2;
		else if (bb >= 5'd2) lg = 3'd1;
		else lg = 3'd0;
		return lg;
	endfunction

endpackage

/* rtl/ttba_div_cell.sv */
// ----------------------------------------------------------------------------
// ttba_div_cell
// One restoring-division step: resolves one quotient bit of the macro-tile
// index and passes remainder, dividend/quotient and side data downstream.
// ----------------------------------------------------------------------------
module ttba_div_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [ttba_pkg::GRP_W-1:0]   divisor,
	input  logic                         up_valid,
	input  ttba_pkg::stage_t             up_stage,
	output logic                         up_ready,
	output logic                         dn_valid,
	output ttba_pkg::stage_t             dn_stage,
	input  logic                         dn_ready
);
	import ttba_pkg::*;

	logic [GRP_W-1:0] trial;
	logic             take;
	stage_t           nxt;
	logic             valid_q;
	stage_t           stage_q;

	// partial remainder with the next dividend bit shifted in
	assign trial = {up_stage.rem, up_stage.data[QUO_W-1]};
	assign take  = trial >= divisor;

	always_comb begin
		nxt      = up_stage;
		nxt.rem  = take ? REM_W'(trial - divisor) : trial[REM_W-1:0];
		nxt.data = {up_stage.data[QUO_W-2:0], take};
	end

	assign up_ready = !valid_q || dn_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready && up_valid) begin
			stage_q <= nxt;
		end
	end

	assign dn_valid = valid_q;
	assign dn_stage = stage_q;

endmodule

/* rtl/tiled_texture_block_address.sv */
// ----------------------------------------------------------------------------
// tiled_texture_block_address
// Maps a tiled block offset to linear x/y and byte indexes with bound check.
// ----------------------------------------------------------------------------
// Takes one transaction per clock unless rsp_ready holds the pipe, and returns
// one result per transaction, in order, from the result register. There are
// 22 register stages: the offset decode register, 18 divider cells that split
// the macro-tile index into row and column (one quotient bit per cell), then
// x/y assembly, the row-times-width multiply and the byte index / bound check
// stage. Each stage moves on as soon as the stage after it is free, so bubbles
// collapse and a waiting result does not block new transactions while the pipe
// has room. Configuration must be written only while no transaction is in
// flight.
module tiled_texture_block_address (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [ttba_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [ttba_pkg::CFG_W-1:0]        cfg_data,
	input  logic                              req_valid,
	output logic                              req_ready,
	input  logic [ttba_pkg::OFS_W-1:0]        tiled_offset,
	output logic                              rsp_valid,
	input  logic                              rsp_ready,
	output logic [ttba_pkg::X_W-1:0]          block_x,
	output logic [ttba_pkg::Y_W-1:0]          block_y,
	output logic [ttba_pkg::TIDX_W-1:0]       tiled_byte_index,
	output logic [ttba_pkg::LIDX_W-1:0]       linear_byte_index,
	output logic                              out_of_range
);
	import ttba_pkg::*;

	// configuration
	logic [WIDTH_W-1:0] width_q;
	logic [BB_W-1:0]    bbytes_q;
	logic [CFG_W-1:0]   tiled_len_q;
	logic [CFG_W-1:0]   lin_len_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q     <= WIDTH_W'(32);
			bbytes_q    <= BB_W'(4);
			tiled_len_q <= '0;
			lin_len_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WIDTH:      width_q     <= cfg_data[WIDTH_W-1:0];
				REG_BLOCK_SIZE: bbytes_q    <= cfg_data[BB_W-1:0];
				REG_TILED_LEN:  tiled_len_q <= cfg_data;
				REG_LINEAR_LEN: lin_len_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [LG_W-1:0]    lg;
	logic [WIDTH_W-1:0] w_sat;
	logic [WIDTH_W-1:0] w_pad;
	logic [GRP_W-1:0]   groups;

	assign lg     = size_log2(bbytes_q);
	assign w_sat  = (width_q > MAX_WIDTH_BLOCKS) ? MAX_WIDTH_BLOCKS : width_q;
	assign w_pad  = w_sat + WIDTH_W'(31);
	// zero width still divides by one group
	assign groups = (w_pad[WIDTH_W-1:5] == '0) ? GRP_W'(1) : GRP_W'(w_pad[WIDTH_W-1:5]);

	// ------------------------------------------------------------------
	// stage 1: offset decode
	// ------------------------------------------------------------------
	logic [TIDX_W-1:0] ob;
	logic [OT_W-1:0]   ot;
	logic [OT_W-1:0]   ot_sh;
	logic [OT_W-2:0]   ux_t;
	logic [OT_W-1:0]   uy_mask;
	logic [OT_W-1:0]   uy_sum;
	logic [OT_W-1:0]   uy_sh;
	stage_t            front;

	assign ob      = TIDX_W'(tiled_offset) << lg;
	assign ot      = OT_W'({ob[27:12], 9'b0}) + OT_W'({ob[10:8], 6'b0}) + OT_W'(ob[5:0]);
	assign ot_sh   = ot >> lg;
	assign ux_t    = {ot[24:5], ot[3:0]};
	assign uy_mask = ((OT_W'(64) << lg) - OT_W'(1)) & ~OT_W'(31);
	assign uy_sum  = (ot & uy_mask) + OT_W'({ot[3:0], 1'b0});
	assign uy_sh   = (uy_sum >> 3) >> lg;

	always_comb begin
		front         = '0;
		front.data    = ot_sh[OT_W-1:7];
		front.side.off = tiled_offset;
		front.side.tx = {ot_sh[6], 1'b0} + ob[7:6];
		front.side.ty = {ob[11], ot_sh[6]};
		front.side.ux = 3'(ux_t >> lg);
		front.side.uy = {uy_sh[2:1], 1'b0};
		front.side.b4 = ot[4];
	end

	logic [QUO_W:0] cell_vld;
	logic [QUO_W:0] cell_rdy;
	stage_t         cell_stage [QUO_W+1];
	logic           v_s1;
	stage_t         st_s1;

	assign req_ready = !v_s1 || cell_rdy[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (req_ready) begin
			v_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			st_s1 <= front;
		end
	end

	assign cell_vld[0]   = v_s1;
	assign cell_stage[0] = st_s1;

	// ------------------------------------------------------------------
	// divider cell chain: macro-tile index / groups
	// ------------------------------------------------------------------
	for (genvar i = 0; i < QUO_W; i++) begin : g_cell
		ttba_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.divisor  (groups),
			.up_valid (cell_vld[i]),
			.up_stage (cell_stage[i]),
			.up_ready (cell_rdy[i]),
			.dn_valid (cell_vld[i+1]),
			.dn_stage (cell_stage[i+1]),
			.dn_ready (cell_rdy[i+1])
		);
	end

	// ------------------------------------------------------------------
	// stage 20: x/y assembly
	// ------------------------------------------------------------------
	logic             v_s20, v_s21, v_s22;
	logic             rdy_s21, rdy_s22;
	logic [X_W-1:0]   x_c;
	logic [Y_W-1:0]   y_c;
	logic [X_W-1:0]   x_s20, x_s21;
	logic [Y_W-1:0]   y_s20, y_s21;
	logic [OFS_W-1:0] off_s20, off_s21;
	stage_t           last;

	assign last = cell_stage[QUO_W];
	assign x_c  = X_W'({last.rem, last.side.tx, 3'b000}) + X_W'(last.side.ux);
	assign y_c  = Y_W'({last.data, last.side.ty, 3'b000}) + Y_W'(last.side.uy)
	            + Y_W'(last.side.b4);

	assign cell_rdy[QUO_W] = !v_s20 || rdy_s21;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s20 <= 1'b0;
		end else if (cell_rdy[QUO_W]) begin
			v_s20 <= cell_vld[QUO_W];
		end
	end

	always_ff @(posedge clk) begin
		if (cell_rdy[QUO_W] && cell_vld[QUO_W]) begin
			x_s20   <= x_c;
			y_s20   <= y_c;
			off_s20 <= last.side.off;
		end
	end

	// ------------------------------------------------------------------
	// stage 21: row times width
	// ------------------------------------------------------------------
	logic [MUL_W-1:0] prod_s21;

	assign rdy_s21 = !v_s21 || rdy_s22;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s21 <= 1'b0;
		end else if (rdy_s21) begin
			v_s21 <= v_s20;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s21 && v_s20) begin
			prod_s21 <= MUL_W'(y_s20) * MUL_W'(w_sat);
			x_s21    <= x_s20;
			y_s21    <= y_s20;
			off_s21  <= off_s20;
		end
	end

	// ------------------------------------------------------------------
	// stage 22: byte indexes, bound check, result register
	// ------------------------------------------------------------------
	logic [MUL_W-1:0]  lsum;
	logic [LIDX_W-1:0] lidx_c;
	logic [LIDX_W-1:0] lend_c;
	logic [TIDX_W-1:0] tidx_c;
	logic [TEND_W-1:0] tend_c;
	logic              oor_c;

	logic [X_W-1:0]    x_s22;
	logic [Y_W-1:0]    y_s22;
	logic [TIDX_W-1:0] tidx_s22;
	logic [LIDX_W-1:0] lidx_s22;
	logic              oor_s22;

	assign lsum   = prod_s21 + MUL_W'(x_s21);
	assign lidx_c = LIDX_W'(lsum) << lg;
	// index + block size == (index_in_blocks + 1) << lg
	assign lend_c = (LIDX_W'(lsum) + LIDX_W'(1)) << lg;
	assign tidx_c = TIDX_W'(off_s21) << lg;
	assign tend_c = (TEND_W'(off_s21) + TEND_W'(1)) << lg;
	assign oor_c  = (CFG_W'(tend_c) > tiled_len_q) || (lend_c > LIDX_W'(lin_len_q));

	assign rdy_s22 = !v_s22 || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s22 <= 1'b0;
		end else if (rdy_s22) begin
			v_s22 <= v_s21;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s22 && v_s21) begin
			x_s22    <= x_s21;
			y_s22    <= y_s21;
			tidx_s22 <= tidx_c;
			lidx_s22 <= lidx_c;
			oor_s22  <= oor_c;
		end
	end

	assign rsp_valid         = v_s22;
	assign block_x           = x_s22;
	assign block_y           = y_s22;
	assign tiled_byte_index  = tidx_s22;
	assign linear_byte_index = lidx_s22;
	assign out_of_range      = oor_s22;

	// ------------------------------------------------------------------
	// checks
	// ------------------------------------------------------------------
	a_idle_accepts: assert property (@(posedge clk) disable iff (!arst_n)
		!rsp_valid |-> req_ready)
		else $error("input stalled with an empty result register");

	a_accept_fills: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> v_s1)
		else $error("accepted transaction not captured by decode stage");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v_s21 && rsp_valid && !rsp_ready |=> v_s21)
		else $error("multiply stage dropped a transaction under stall");

endmodule
